@@ rtl/core/backbone_angle_structure_labeler_defines.svh @@
// Assertion macros for the backbone angle structure labeler
// Used by the top level; expects clk and rst_n in the including scope
`ifndef BACKBONE_ANGLE_STRUCTURE_LABELER_DEFINES_SVH
`define BACKBONE_ANGLE_STRUCTURE_LABELER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BAS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BAS_ASSERT_IMPL(lbl, ante, cons)
`define BAS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/bas_pkg.sv @@
// Shared types, constants and the label window step function
// No dependencies
package bas_pkg;

    // angle format: 2^(ANGLE_BITS-1) units equal pi
    localparam int ANGLE_BITS = 16;
    localparam int HALF_TURN  = 1 << (ANGLE_BITS - 1);

    // class centers, rounded half up in magnitude
    localparam int RH_PHI = -((HALF_TURN + 1) / 3);
    localparam int RH_PSI = -((HALF_TURN + 2) / 4);
    localparam int LH_PHI = (HALF_TURN + 1) / 3;
    localparam int LH_PSI = (HALF_TURN + 2) / 4;
    localparam int ST_PHI = -((HALF_TURN * 11 + 9) / 18);
    localparam int ST_PSI = (HALF_TURN * 13 + 9) / 18;

    // datapath widths
    localparam int DIFF_W   = ANGLE_BITS + 1;
    localparam int SQ_W     = 2 * ANGLE_BITS;
    localparam int SUM_W    = SQ_W + 1;
    localparam int RADIUS_W = 15;
    localparam int RSQ_W    = 2 * RADIUS_W;
    localparam int CMP_W    = (SUM_W > RSQ_W) ? SUM_W : RSQ_W;
    localparam int RUN_W    = 2;
    localparam int SEEN_W   = 3;
    localparam int CFG_DATA_W = RADIUS_W;
    localparam int CFG_IDX_W  = 2;

    // register reset values
    localparam logic [RADIUS_W-1:0] RADIUS_RESET     = RADIUS_W'(5461);
    localparam logic [RUN_W-1:0]    HELIX_RUN_RESET  = RUN_W'(3);
    localparam logic [RUN_W-1:0]    STRAND_RUN_RESET = RUN_W'(2);

    typedef logic signed [ANGLE_BITS-1:0] angle_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic [SUM_W-1:0]             sum_t;

    localparam diff_t RH_PHI_C = DIFF_W'(RH_PHI);
    localparam diff_t RH_PSI_C = DIFF_W'(RH_PSI);
    localparam diff_t LH_PHI_C = DIFF_W'(LH_PHI);
    localparam diff_t LH_PSI_C = DIFF_W'(LH_PSI);
    localparam diff_t ST_PHI_C = DIFF_W'(ST_PHI);
    localparam diff_t ST_PSI_C = DIFF_W'(ST_PSI);

    typedef enum logic [1:0] {
        LBL_COIL   = 2'd0,
        LBL_RHELIX = 2'd1,
        LBL_LHELIX = 2'd2,
        LBL_STRAND = 2'd3
    } label_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_RADIUS  = 2'd0,
        CFG_HELIX_MIN_RUN  = 2'd1,
        CFG_STRAND_MIN_RUN = 2'd2
    } cfg_index_t;

    // squared distances of one residue to the three centers
    typedef struct packed {
        sum_t sum_rh;
        sum_t sum_lh;
        sum_t sum_st;
        logic angles_valid;
        logic chain_end;
    } dist_t;

    // class and label window of the current chain
    typedef struct packed {
        label_t           cw0;
        label_t           cw1;
        label_t           cw2;
        logic [RUN_W-1:0] run;
        label_t           lw0;
        label_t           prior;
    } win_t;

    localparam win_t WIN_CLEAR = win_t'('0);

    typedef struct packed {
        label_t label;
        logic   assigned;
        logic   chain_done;
    } result_t;

    // up to four results produced by one residue
    typedef struct packed {
        logic [2:0]       count;
        result_t [3:0]    entry;
    } batch_t;

    // push one class, decide the raw label two back, smooth the one three back
    function automatic win_t win_step(win_t s, label_t cls,
                                      logic [RUN_W-1:0] helix_min,
                                      logic [RUN_W-1:0] strand_min);
        win_t             n;
        logic [2:0]       total;
        logic [RUN_W-1:0] need;
        label_t           raw;
        n.cw0 = cls;
        n.cw1 = s.cw0;
        n.cw2 = s.cw1;
        if (s.cw1 == s.cw2)
        begin
            n.run = (s.run != RUN_W'(3)) ? s.run + RUN_W'(1) : s.run;
        end
        else
        begin
            n.run = RUN_W'(1);
        end
        total = 3'(n.run);
        if (n.cw1 == n.cw2)
        begin
            total = total + 3'd1;
            if (n.cw0 == n.cw1)
            begin
                total = total + 3'd1;
            end
        end
        need = (n.cw2 == LBL_STRAND) ? strand_min : helix_min;
        raw  = (n.cw2 != LBL_COIL && total >= 3'(need)) ? n.cw2 : LBL_COIL;
        n.lw0 = raw;
        if (s.prior == raw && s.prior != LBL_COIL)
        begin
            n.prior = s.prior;
        end
        else
        begin
            n.prior = s.lw0;
        end
        return n;
    endfunction

endpackage

@@ rtl/core/bas_in_if.sv @@
// Residue request channel: valid/ready handshake with the angle payload
// Depends on bas_pkg
interface bas_in_if
    import bas_pkg::*;
();
    logic   valid;
    logic   ready;
    angle_t phi;
    angle_t psi;
    logic   angles_valid;
    logic   chain_end;

    modport source (output valid, phi, psi, angles_valid, chain_end, input ready);
    modport sink   (input valid, phi, psi, angles_valid, chain_end, output ready);
endinterface

@@ rtl/core/bas_out_if.sv @@
// Label request channel: valid/ready handshake with the result payload
// Depends on bas_pkg
interface bas_out_if
    import bas_pkg::*;
();
    logic   valid;
    logic   ready;
    label_t label;
    logic   assigned;
    logic   chain_done;

    modport source (output valid, label, assigned, chain_done, input ready);
    modport sink   (input valid, label, assigned, chain_done, output ready);
endinterface

@@ rtl/core/bas_distance.sv @@
// Input register and squared-distance stage for the three class centers
// Depends on bas_pkg and bas_in_if
module bas_distance
    import bas_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bas_in_if.sink     in_ch,
    output logic       d_valid,
    output dist_t      d_data,
    input  logic       d_ready
);

    logic   a_valid_reg;
    angle_t a_phi_reg;
    angle_t a_psi_reg;
    logic   a_av_reg;
    logic   a_end_reg;
    logic   b_valid_reg;
    dist_t  b_data_reg;
    dist_t  b_data_next;
    logic   b_free;
    logic   a_move;

    // squared distance to one center
    function automatic sum_t dist_sq(angle_t phi, angle_t psi, diff_t cphi, diff_t cpsi);
        diff_t                 dp;
        diff_t                 dq;
        logic signed [SQ_W:0]  p;
        logic signed [SQ_W:0]  q;
        dp = DIFF_W'(phi) - cphi;
        dq = DIFF_W'(psi) - cpsi;
        p  = dp * dp;
        q  = dq * dq;
        return SUM_W'(p[SQ_W-1:0]) + SUM_W'(q[SQ_W-1:0]);
    endfunction

    // stage handshake
    assign b_free      = !b_valid_reg || d_ready;
    assign a_move      = a_valid_reg && b_free;
    assign in_ch.ready = !a_valid_reg || b_free;

    // distance logic
    always_comb
    begin
        b_data_next.sum_rh       = dist_sq(a_phi_reg, a_psi_reg, RH_PHI_C, RH_PSI_C);
        b_data_next.sum_lh       = dist_sq(a_phi_reg, a_psi_reg, LH_PHI_C, LH_PSI_C);
        b_data_next.sum_st       = dist_sq(a_phi_reg, a_psi_reg, ST_PHI_C, ST_PSI_C);
        b_data_next.angles_valid = a_av_reg;
        b_data_next.chain_end    = a_end_reg;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                a_valid_reg <= in_ch.valid;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            a_phi_reg <= in_ch.phi;
            a_psi_reg <= in_ch.psi;
            a_av_reg  <= in_ch.angles_valid;
            a_end_reg <= in_ch.chain_end;
        end
        if (a_move)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign d_valid = b_valid_reg;
    assign d_data  = b_data_reg;

endmodule

@@ rtl/core/bas_labeler.sv @@
// Classification, run filter, smoothing and chain-end result batches
// Depends on bas_pkg
module bas_labeler
    import bas_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             d_valid,
    input  dist_t            d_data,
    output logic             d_ready,
    input  logic [RSQ_W-1:0] radius_sq,
    input  logic [RUN_W-1:0] helix_min_run,
    input  logic [RUN_W-1:0] strand_min_run,
    input  logic             q_space,
    output logic             res_load,
    output batch_t           res_batch
);

    win_t              win_reg;
    win_t              win_next;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;
    logic              fire;
    logic [CMP_W-1:0]  rsq;
    label_t            hit;
    label_t            cls;
    win_t              st1;
    win_t              st2;
    win_t              st3;
    win_t              st4;

    assign fire     = d_valid && q_space;
    assign d_ready  = q_space;
    assign res_load = fire;
    assign rsq      = CMP_W'(radius_sq);

    // region test, first match wins
    always_comb
    begin
        if (CMP_W'(d_data.sum_rh) < rsq)
        begin
            hit = LBL_RHELIX;
        end
        else if (CMP_W'(d_data.sum_lh) < rsq)
        begin
            hit = LBL_LHELIX;
        end
        else if (CMP_W'(d_data.sum_st) < rsq)
        begin
            hit = LBL_STRAND;
        end
        else
        begin
            hit = LBL_COIL;
        end
        // terminal and missing-atom residues get no class
        if (d_data.angles_valid && seen_reg != '0 && !d_data.chain_end)
        begin
            cls = hit;
        end
        else
        begin
            cls = LBL_COIL;
        end
    end

    // window steps: one for the residue, three more for the chain-end flush
    always_comb
    begin
        st1 = win_step(win_reg, cls, helix_min_run, strand_min_run);
        st2 = win_step(st1, LBL_COIL, helix_min_run, strand_min_run);
        st3 = win_step(st2, LBL_COIL, helix_min_run, strand_min_run);
        st4 = win_step(st3, LBL_COIL, helix_min_run, strand_min_run);
    end

    // result batch and next state
    always_comb
    begin
        res_batch.count = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            res_batch.entry[i] = '{label: LBL_COIL, assigned: 1'b0, chain_done: 1'b0};
        end
        win_next  = st1;
        seen_next = (seen_reg < SEEN_W'(4)) ? seen_reg + SEEN_W'(1) : seen_reg;
        if (!d_data.chain_end)
        begin
            if (seen_reg >= SEEN_W'(3))
            begin
                res_batch.count    = 3'd1;
                res_batch.entry[0] = '{label: st1.prior, assigned: 1'b1, chain_done: 1'b0};
            end
        end
        else
        begin
            win_next  = WIN_CLEAR;
            seen_next = '0;
            if (seen_reg < SEEN_W'(3))
            begin
                // short chain: one unassigned result per residue
                res_batch.count = 3'(seen_reg) + 3'd1;
                for (int i = 0; i < 3; i++)
                begin
                    if (SEEN_W'(i) <= seen_reg)
                    begin
                        res_batch.entry[i] = '{label: LBL_COIL, assigned: 1'b0,
                                               chain_done: (SEEN_W'(i) == seen_reg)};
                    end
                end
            end
            else
            begin
                res_batch.count    = 3'd4;
                res_batch.entry[0] = '{label: st1.prior, assigned: 1'b1, chain_done: 1'b0};
                res_batch.entry[1] = '{label: st2.prior, assigned: 1'b1, chain_done: 1'b0};
                res_batch.entry[2] = '{label: st3.prior, assigned: 1'b1, chain_done: 1'b0};
                res_batch.entry[3] = '{label: st4.prior, assigned: 1'b1, chain_done: 1'b1};
            end
        end
    end

    // chain state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= WIN_CLEAR;
            seen_reg <= '0;
        end
        else if (fire)
        begin
            win_reg  <= win_next;
            seen_reg <= seen_next;
        end
    end

endmodule

@@ rtl/core/bas_result_buf.sv @@
// Four-entry result buffer, loaded as a batch, drained one per cycle while out_ch is ready
// Depends on bas_pkg and bas_out_if
module bas_result_buf
    import bas_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       res_load,
    input  batch_t     res_batch,
    output logic       q_space,
    bas_out_if.source  out_ch
);

    logic [2:0]    count_reg;
    logic [2:0]    count_next;
    result_t [3:0] slot_reg;
    result_t [3:0] slot_next;
    logic          pop;

    assign pop     = (count_reg != 3'd0) && out_ch.ready;
    assign q_space = (count_reg == 3'd0) || (count_reg == 3'd1 && out_ch.ready);

    // load replaces the buffer, pop shifts toward the head
    always_comb
    begin
        count_next = count_reg;
        slot_next  = slot_reg;
        if (res_load)
        begin
            count_next = res_batch.count;
            slot_next  = res_batch.entry;
        end
        else if (pop)
        begin
            count_next = count_reg - 3'd1;
            for (int i = 0; i < 3; i++)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign out_ch.valid      = (count_reg != 3'd0);
    assign out_ch.label      = slot_reg[0].label;
    assign out_ch.assigned   = slot_reg[0].assigned;
    assign out_ch.chain_done = slot_reg[0].chain_done;

endmodule

@@ rtl/core/backbone_angle_structure_labeler.sv @@
// Backbone angle structure labeler. One residue (phi, psi) request is taken
// per cycle while nothing stalls. An input register, a squared-distance
// register and the labeler feed a four-entry result buffer; labels trail their
// input by three residues. A non-chain-end residue gives zero or one result and
// keeps that rate while the output is ready. A chain end gives four results (one
// per residue for chains under four residues), handed out one per cycle while
// the output is ready; the next residue enters the labeler only after that batch
// has drained to its last entry. The user must write registers only while the
// block is idle; the block itself does not enforce this.
// Depends on bas_pkg, bas_in_if, bas_out_if, bas_distance, bas_labeler,
// bas_result_buf and the defines header
`include "backbone_angle_structure_labeler_defines.svh"

module backbone_angle_structure_labeler
    import bas_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bas_in_if.sink                in_ch,
    bas_out_if.source             out_ch
);

    logic [RADIUS_W-1:0] region_radius_reg;
    logic [RUN_W-1:0]    helix_min_run_reg;
    logic [RUN_W-1:0]    strand_min_run_reg;
    logic [RSQ_W-1:0]    radius_sq_reg;
    logic                d_valid;
    dist_t               d_data;
    logic                d_ready;
    logic                q_space;
    logic                res_load;
    batch_t              res_batch;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_radius_reg  <= RADIUS_RESET;
            helix_min_run_reg  <= HELIX_RUN_RESET;
            strand_min_run_reg <= STRAND_RUN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REGION_RADIUS:  region_radius_reg  <= cfg_data;
                CFG_HELIX_MIN_RUN:  helix_min_run_reg  <= cfg_data[RUN_W-1:0];
                CFG_STRAND_MIN_RUN: strand_min_run_reg <= cfg_data[RUN_W-1:0];
                default:            ;
            endcase
        end
    end

    // squared radius, refreshed every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_sq_reg <= RSQ_W'(RADIUS_RESET) * RSQ_W'(RADIUS_RESET);
        end
        else
        begin
            radius_sq_reg <= RSQ_W'(region_radius_reg) * RSQ_W'(region_radius_reg);
        end
    end

    // distance stage
    bas_distance u_distance (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .d_valid (d_valid),
        .d_data  (d_data),
        .d_ready (d_ready)
    );

    // labeling stage
    bas_labeler u_labeler (
        .clk            (clk),
        .rst_n          (rst_n),
        .d_valid        (d_valid),
        .d_data         (d_data),
        .d_ready        (d_ready),
        .radius_sq      (radius_sq_reg),
        .helix_min_run  (helix_min_run_reg),
        .strand_min_run (strand_min_run_reg),
        .q_space        (q_space),
        .res_load       (res_load),
        .res_batch      (res_batch)
    );

    // result buffer
    bas_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res_batch (res_batch),
        .q_space   (q_space),
        .out_ch    (out_ch)
    );

    // unassigned results carry coil
    `BAS_ASSERT_IMPL(a_unassigned_coil, out_ch.valid && !out_ch.assigned, out_ch.label == LBL_COIL)
    // the last residue of a chain is always coil
    `BAS_ASSERT_IMPL(a_done_coil, out_ch.valid && out_ch.chain_done, out_ch.label == LBL_COIL)
    // a short-chain batch of unassigned results drains without gaps
    `BAS_ASSERT_NEXT(a_batch_burst, out_ch.valid && out_ch.ready && !out_ch.assigned && !out_ch.chain_done, out_ch.valid)

endmodule
